/* hw/rtl/cdcs_pkg.sv */
package cdcs_pkg;

	localparam int CHANNELS = 64;
	localparam int TAPS     = 4;
	localparam int HIST_LEN = TAPS - 1;

	localparam int DATA_W = 16;
	localparam int TYPE_W = 2;
	localparam int CH_W   = 6;
	localparam int TAP_W  = 2;
	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + 1 + $clog2(TAPS);
	localparam int SIG_W  = DATA_W + 1;
	localparam int SILU_W = DATA_W + SIG_W;

	localparam logic RES_SAMPLE = 1'b0;
	localparam logic RES_HIST   = 1'b1;

	typedef enum logic [TYPE_W-1:0] {
		REQ_WR_WEIGHT = 2'd0,
		REQ_WR_HIST   = 2'd1,
		REQ_SAMPLE    = 2'd2,
		REQ_RD_HIST   = 2'd3
	} req_t;

	typedef logic [TAPS-1:0][DATA_W-1:0]     wrow_t;
	typedef logic [HIST_LEN-1:0][DATA_W-1:0] hrow_t;

	typedef struct packed {
		logic              w_en;
		logic              h_en;
		logic [ADDR_W-1:0] addr;
		wrow_t             wrow;
		hrow_t             hrow;
	} store_wr_t;

	typedef logic [255:0][DATA_W-1:0] sig_tab_t;

	// unsigned quotient by shift and subtract, table build only
	function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid at the start of each 1/16 bin over [-8,8), unsigned q0.15
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t    t;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] p;
		t = '0;
		e = 64'd1 << 32;
		for (int k = 0; k <= 128; k++) begin
			d = (64'd1 << 32) + e;
			p = div_u64((64'd1 << 47) + (d >> 1), d);
			if (k < 128) begin
				t[128 + k] = p[DATA_W-1:0];
			end
			if (k > 0) begin
				t[128 - k] = DATA_W'(32'd32768 - p[31:0]);
			end
			e = (e * 64'd4034748383 + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

/* hw/rtl/cdcs_store.sv */
module cdcs_store (
	input  logic                           clk,
	input  cdcs_pkg::store_wr_t            wr,
	input  logic                           rd_en,
	input  logic [cdcs_pkg::ADDR_W-1:0]    rd_addr,
	output cdcs_pkg::wrow_t                rd_wrow,
	output cdcs_pkg::hrow_t                rd_hrow
);
	import cdcs_pkg::*;

	// one row per channel
	wrow_t wmem [CHANNELS];
	hrow_t hmem [CHANNELS];

	always_ff @(posedge clk) begin
		if (wr.w_en) begin
			wmem[wr.addr] <= wr.wrow;
		end
		if (wr.h_en) begin
			hmem[wr.addr] <= wr.hrow;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_wrow <= wmem[rd_addr];
			rd_hrow <= hmem[rd_addr];
		end
	end

endmodule

/* hw/rtl/cdcs_mac.sv */
module cdcs_mac (
	input  logic                                clk,
	input  cdcs_pkg::wrow_t                     wrow,
	input  cdcs_pkg::hrow_t                     hrow,
	input  logic signed [cdcs_pkg::DATA_W-1:0]  sample,
	output logic signed [cdcs_pkg::DATA_W-1:0]  sum_s3
);
	import cdcs_pkg::*;

	logic signed [DATA_W-1:0] wgt [TAPS];
	logic signed [DATA_W-1:0] win [TAPS];
	logic signed [PROD_W-1:0] prod_s1 [TAPS];
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  shr;
	logic                     fits;

	// window oldest first, new sample last
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			wgt[k] = $signed(wrow[k]);
		end
		for (int k = 0; k < HIST_LEN; k++) begin
			win[k] = $signed(hrow[k]);
		end
		win[TAPS-1] = sample;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			prod_s1[k] <= wgt[k] * win[k];
		end
	end

	always_comb begin
		acc_d = '0;
		for (int k = 0; k < TAPS; k++) begin
			acc_d = acc_d + ACC_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		acc_s2 <= acc_d;
	end

	// round half up to q7.8, then saturate
	assign rnd  = acc_s2 + ACC_W'(1 << 13);
	assign shr  = rnd >>> 14;
	assign fits = (shr[ACC_W-1:DATA_W-1] == '0) || (shr[ACC_W-1:DATA_W-1] == '1);

	always_ff @(posedge clk) begin
		if (fits) begin
			sum_s3 <= shr[DATA_W-1:0];
		end else if (shr[ACC_W-1]) begin
			sum_s3 <= {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_s3 <= {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

endmodule

/* hw/rtl/cdcs_silu.sv */
module cdcs_silu (
	input  logic                                clk,
	input  logic signed [cdcs_pkg::DATA_W-1:0]  s,
	output logic signed [cdcs_pkg::DATA_W-1:0]  y
);
	import cdcs_pkg::*;

	logic [7:0]               idx;
	logic signed [SIG_W-1:0]  sig;
	logic signed [SILU_W-1:0] prod_s4;
	logic signed [SILU_W-1:0] rnd;

	assign idx = {~s[11], s[10:4]};

	always_comb begin
		if (!s[15] && (s[14:11] != 4'b0000)) begin
			sig = SIG_W'(32768);
		end else if (s[15] && (s[14:11] != 4'b1111)) begin
			sig = '0;
		end else begin
			sig = {1'b0, SIG_TAB[idx]};
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= s * sig;
	end

	assign rnd = (prod_s4 + SILU_W'(1 << 14)) >>> 15;
	assign y   = rnd[DATA_W-1:0];

endmodule

/* hw/rtl/causal_depthwise_conv_silu.sv */
// weight or history write: the row is read, merged and written back, no result
// history read: the word is taken from the read row into res_q, then registered at the output
// sample: the result passes the row read of the state memories, the mac and silu stages and
//   the output register; the input stalls until the item retires, and out_stall can hold it
// after reset a sweep over all CHANNELS rows zeroes both memories, input stalled meanwhile
module causal_depthwise_conv_silu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cdcs_pkg::TYPE_W-1:0]         req_type,
	input  logic [cdcs_pkg::CH_W-1:0]           channel,
	input  logic [cdcs_pkg::TAP_W-1:0]          tap,
	input  logic signed [cdcs_pkg::DATA_W-1:0]  data_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cdcs_pkg::DATA_W-1:0]  result_value,
	output logic                                result_kind
);
	import cdcs_pkg::*;

	typedef enum logic [6:0] {
		ST_CLR  = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_RMW  = 7'b0000100,
		ST_SUM  = 7'b0001000,
		ST_RND  = 7'b0010000,
		ST_SIG  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	state_t                   state_d;
	logic [ADDR_W-1:0]        clr_q;
	logic                     accept;
	logic                     load;
	logic                     out_valid_q;

	req_t                     kind_s1;
	logic                     ch_ok_s1;
	logic [TAP_W-1:0]         tap_s1;
	logic signed [DATA_W-1:0] data_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic [DATA_W-1:0]        res_q;

	wrow_t                    rd_wrow;
	hrow_t                    rd_hrow;
	wrow_t                    wrow_new;
	hrow_t                    hrow_new;
	logic [DATA_W-1:0]        hval;
	store_wr_t                wr;
	logic                     tap_w_ok;
	logic                     tap_h_ok;
	logic signed [DATA_W-1:0] sum_s3;
	logic signed [DATA_W-1:0] silu_y;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign tap_w_ok = 32'(tap_s1) < TAPS;
	assign tap_h_ok = 32'(tap_s1) < HIST_LEN;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req_t'(req_type);
			ch_ok_s1 <= 32'(channel) < CHANNELS;
			tap_s1   <= tap;
			data_s1  <= data_value;
			addr_s1  <= ADDR_W'(channel);
		end
	end

	cdcs_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(channel)),
		.rd_wrow (rd_wrow),
		.rd_hrow (rd_hrow)
	);

	// merge the written word into the row, or shift the new sample in
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			wrow_new[k] = (32'(tap_s1) == k) ? data_s1 : rd_wrow[k];
		end
		hval = '0;
		for (int k = 0; k < HIST_LEN; k++) begin
			if (32'(tap_s1) == k) begin
				hval = rd_hrow[k];
			end
		end
		if (kind_s1 == REQ_SAMPLE) begin
			for (int k = 0; k < HIST_LEN - 1; k++) begin
				hrow_new[k] = rd_hrow[k+1];
			end
			hrow_new[HIST_LEN-1] = data_s1;
		end else begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hrow_new[k] = (32'(tap_s1) == k) ? data_s1 : rd_hrow[k];
			end
		end
	end

	always_comb begin
		wr = '0;
		if (state_q == ST_CLR) begin
			wr.w_en = 1'b1;
			wr.h_en = 1'b1;
			wr.addr = clr_q;
		end else if (state_q == ST_RMW) begin
			wr.addr = addr_s1;
			wr.wrow = wrow_new;
			wr.hrow = hrow_new;
			wr.w_en = (kind_s1 == REQ_WR_WEIGHT) && ch_ok_s1 && tap_w_ok;
			wr.h_en = ((kind_s1 == REQ_WR_HIST) && ch_ok_s1 && tap_h_ok)
				|| ((kind_s1 == REQ_SAMPLE) && ch_ok_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RMW) begin
			res_q <= ((kind_s1 == REQ_RD_HIST) && ch_ok_s1 && tap_h_ok) ? hval : '0;
		end
	end

	cdcs_mac u_mac (
		.clk    (clk),
		.wrow   (rd_wrow),
		.hrow   (rd_hrow),
		.sample (data_s1),
		.sum_s3 (sum_s3)
	);

	cdcs_silu u_silu (
		.clk (clk),
		.s   (sum_s3),
		.y   (silu_y)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (32'(clr_q) == CHANNELS - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RMW;
				end
			end
			ST_RMW: begin
				if ((kind_s1 == REQ_WR_WEIGHT) || (kind_s1 == REQ_WR_HIST)) begin
					state_d = ST_IDLE;
				end else if ((kind_s1 == REQ_SAMPLE) && ch_ok_s1) begin
					state_d = ST_SUM;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SUM: state_d = ST_RND;
			ST_RND: state_d = ST_SIG;
			ST_SIG: state_d = ST_OUT;
			ST_OUT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load || (out_valid_q && out_stall);
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_value <= ((kind_s1 == REQ_SAMPLE) && ch_ok_s1) ? silu_y : res_q;
			result_kind  <= (kind_s1 == REQ_RD_HIST) ? RES_HIST : RES_SAMPLE;
		end
	end

	a_wr_only_clr_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.w_en || wr.h_en) |-> (state_q == ST_CLR || state_q == ST_RMW))
		else $error("state memory written outside clear or update");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word appeared without a finished item");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW && (kind_s1 == REQ_WR_WEIGHT || kind_s1 == REQ_WR_HIST))
		|=> state_q == ST_IDLE)
		else $error("write word did not retire");

	a_mac_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (kind_s1 == REQ_SAMPLE && ch_ok_s1))
		else $error("filter path entered without a valid sample");

endmodule

/* test/tb_causal_depthwise_conv_silu.sv */
module tb_causal_depthwise_conv_silu;
	import cdcs_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     kind;
	} conv_result_t;

	class conv_scoreboard;
		logic signed [DATA_W-1:0] weights [CHANNELS][TAPS];
		logic signed [DATA_W-1:0] history [CHANNELS][HIST_LEN];
		int                       sig_lut [256];
		conv_result_t             expected_q [$];
		int                       errors;

		function new();
			longint unsigned e;
			longint unsigned d;
			longint unsigned p;
			errors = 0;
			foreach (weights[c, t]) weights[c][t] = '0;
			foreach (history[c, t]) history[c][t] = '0;
			// sigmoid at the start of each 1/16 bin, q0.15, exp(-k/16) stepped in q32
			e = 64'd1 << 32;
			for (int k = 0; k <= 128; k++) begin
				d = (64'd1 << 32) + e;
				p = ((64'd1 << 47) + d / 2) / d;
				if (k < 128) begin
					sig_lut[128 + k] = int'(p);
				end
				if (k > 0) begin
					sig_lut[128 - k] = 32768 - int'(p);
				end
				e = (e * 64'd4034748383 + (64'd1 << 31)) >> 32;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		function logic signed [DATA_W-1:0] filter_sample(int ch, logic signed [DATA_W-1:0] x);
			longint acc;
			longint s;
			longint y;
			int     sig;
			acc = 0;
			for (int k = 0; k < HIST_LEN; k++) begin
				acc += longint'(weights[ch][k]) * longint'(history[ch][k]);
			end
			acc += longint'(weights[ch][TAPS-1]) * longint'(x);
			s = (acc + 8192) >>> 14;
			if (s > 32767) begin
				s = 32767;
			end else if (s < -32768) begin
				s = -32768;
			end
			if (s >= 2048) begin
				sig = 32768;
			end else if (s < -2048) begin
				sig = 0;
			end else begin
				sig = sig_lut[(s >>> 4) + 128];
			end
			y = (s * sig + 16384) >>> 15;
			for (int k = 0; k + 1 < HIST_LEN; k++) begin
				history[ch][k] = history[ch][k+1];
			end
			history[ch][HIST_LEN-1] = x;
			return DATA_W'(y);
		endfunction

		task note_input(req_t kind, logic [CH_W-1:0] ch, logic [TAP_W-1:0] slot,
				logic signed [DATA_W-1:0] val);
			bit           ch_ok;
			conv_result_t res;
			ch_ok = int'(ch) < CHANNELS;
			case (kind)
				REQ_WR_WEIGHT: begin
					if (ch_ok && int'(slot) < TAPS) begin
						weights[ch][slot] = val;
					end
				end
				REQ_WR_HIST: begin
					if (ch_ok && int'(slot) < HIST_LEN) begin
						history[ch][slot] = val;
					end
				end
				REQ_RD_HIST: begin
					res.kind  = RES_HIST;
					res.value = (ch_ok && int'(slot) < HIST_LEN) ? history[ch][slot] : '0;
					expected_q.push_back(res);
				end
				default: begin
					res.kind  = RES_SAMPLE;
					res.value = ch_ok ? filter_sample(ch, val) : '0;
					expected_q.push_back(res);
				end
			endcase
		endtask

		task check_result(logic signed [DATA_W-1:0] value, logic kind);
			conv_result_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word value %0d kind %0b", value, kind));
			end else begin
				exp_res = expected_q.pop_front();
				if (value !== exp_res.value) begin
					report($sformatf("result_value %0d, expected %0d", value, exp_res.value));
				end
				if (kind !== exp_res.kind) begin
					report($sformatf("result_kind %0b, expected %0b", kind, exp_res.kind));
				end
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [TYPE_W-1:0]        req_type;
	logic [CH_W-1:0]          channel;
	logic [TAP_W-1:0]         tap;
	logic signed [DATA_W-1:0] data_value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] result_value;
	logic                     result_kind;

	conv_scoreboard sb = new();

	int tx_gap_pct;
	int rx_stall_pct;
	bit rx_hold_req;
	int rx_hold_left;
	int rx_burst_left;
	int stuck_cycles;

	causal_depthwise_conv_silu i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.channel      (channel),
		.tap          (tap),
		.data_value   (data_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.result_kind  (result_kind)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(result_value, result_kind);
		end
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req  = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else if (rx_burst_left > 0) begin
			rx_burst_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_stall_pct) begin
			rx_burst_left = $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_around(int span);
		return DATA_W'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_weight();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return rand_around(16'h1000);
		end else if (r < 8) begin
			return rand_around(16'h4000);
		end
		return DATA_W'($urandom);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_sample();
		if ($urandom_range(0, 9) < 6) begin
			return rand_around(2400);
		end
		return DATA_W'($urandom);
	endfunction

	task send_item(req_t kind, logic [CH_W-1:0] ch, logic [TAP_W-1:0] slot,
			logic signed [DATA_W-1:0] val);
		int gap;
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		channel    <= ch;
		tap        <= slot;
		data_value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(kind, ch, slot, val);
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task random_item();
		int               r;
		logic [CH_W-1:0]  ch;
		logic [TAP_W-1:0] slot;
		r    = $urandom_range(0, 99);
		ch   = ($urandom_range(0, 4) == 0) ? CH_W'($urandom) : CH_W'($urandom_range(0, 3));
		slot = TAP_W'($urandom_range(0, 3));
		if (r < 70) begin
			send_item(REQ_SAMPLE, ch, slot, rand_sample());
		end else if (r < 80) begin
			send_item(REQ_WR_WEIGHT, ch, slot, rand_weight());
		end else if (r < 88) begin
			send_item(REQ_WR_HIST, ch, slot, rand_sample());
		end else begin
			send_item(REQ_RD_HIST, ch, slot, DATA_W'($urandom));
		end
	endtask

	task directed_items();
		// saturation high on channel 0
		for (int t = 0; t < TAPS; t++) begin
			send_item(REQ_WR_WEIGHT, CH_W'(0), TAP_W'(t), 16'sh7fff);
		end
		for (int t = 0; t < HIST_LEN; t++) begin
			send_item(REQ_WR_HIST, CH_W'(0), TAP_W'(t), 16'sh7fff);
		end
		send_item(REQ_SAMPLE, CH_W'(0), TAP_W'(0), 16'sh7fff);
		// most negative weight on the last channel, both saturation directions
		send_item(REQ_WR_WEIGHT, CH_W'(CHANNELS - 1), TAP_W'(TAPS - 1), 16'sh8000);
		send_item(REQ_SAMPLE, CH_W'(CHANNELS - 1), TAP_W'(0), 16'sh7fff);
		send_item(REQ_SAMPLE, CH_W'(CHANNELS - 1), TAP_W'(3), 16'sh8000);
		// history readback including the slot past the end
		for (int t = 0; t < 4; t++) begin
			send_item(REQ_RD_HIST, CH_W'(0), TAP_W'(t), '0);
		end
		send_item(REQ_WR_HIST, CH_W'(0), TAP_W'(3), 16'sh1234);
		send_item(REQ_RD_HIST, CH_W'(0), TAP_W'(3), '0);
		// unit weight on the newest tap: sigmoid table edges
		send_item(REQ_WR_WEIGHT, CH_W'(1), TAP_W'(TAPS - 1), 16'sh4000);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), 16'sd2047);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), 16'sd2048);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), -16'sd2048);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), -16'sd2049);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), -16'sd1);
		send_item(REQ_SAMPLE, CH_W'(1), TAP_W'(0), 16'sd0);
		send_item(REQ_RD_HIST, CH_W'(CHANNELS - 1), TAP_W'(2), '0);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = '0;
		channel       = '0;
		tap           = '0;
		data_value    = '0;
		out_stall     = 1'b0;
		rx_hold_req   = 1'b0;
		rx_hold_left  = 0;
		rx_burst_left = 0;
		stuck_cycles  = 0;
		tx_gap_pct    = 20;
		rx_stall_pct  = 20;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		directed_items();
		drain();

		for (int c = 0; c < 4; c++) begin
			for (int t = 0; t < TAPS; t++) begin
				send_item(REQ_WR_WEIGHT, CH_W'(c), TAP_W'(t), rand_weight());
			end
		end
		repeat (170) random_item();
		drain();

		// receiver holds off while the sender keeps offering words
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 1'b1;
		repeat (60) random_item();
		drain();

		tx_gap_pct   = 30;
		rx_stall_pct = 0;
		repeat (100) random_item();
		tx_gap_pct   = 0;
		rx_stall_pct = 30;
		repeat (100) random_item();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		repeat (80) random_item();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
